[rtl/tournament_tree_min_select_assert.svh]
// ----------------------------------------------------------------------------
// tournament_tree_min_select assertion macros
// Shared property wrappers for the tournament tree blocks.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_TREE_MIN_SELECT_ASSERT_SVH
`define TOURNAMENT_TREE_MIN_SELECT_ASSERT_SVH

// same-cycle implication
`define TTS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and codes shared by the tournament tree blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

  localparam int MAX_WAYS      = 16;
  localparam int KEY_BITS      = 16;
  localparam int LEAF_BITS     = $clog2(MAX_WAYS);
  localparam int LEAVES        = 1 << LEAF_BITS;
  localparam int NODE_BITS     = LEAF_BITS + 1;   // heap address, root at 1
  localparam int CNT_BITS      = LEAF_BITS + 1;   // counts 0..LEAVES
  localparam int WAYS_BITS     = 5;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAD  = 1'd1;

  localparam logic [WAYS_BITS-1:0] RESET_WAYS = 5'd16;
  localparam logic [KEY_BITS-1:0]  RESET_PAD  = 16'hFFFF;

  // first child pair visited by a build: nodes LEAVES*2-2 and LEAVES*2-1
  localparam logic [NODE_BITS-1:0] BUILD_START = NODE_BITS'(2 * LEAVES - 2);
  localparam logic [NODE_BITS-1:0] ROOT_NODE   = NODE_BITS'(1);

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_RETIRE  = 2'd2;

  typedef struct packed {
    logic [1:0]          operation;
    logic [KEY_BITS-1:0] value;
    logic                last_load;
  } request_t;

  typedef struct packed {
    logic [3:0]          winner_index;
    logic [KEY_BITS-1:0] winner_value;
    logic                load_error;
  } result_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [LEAF_BITS-1:0] leaf;
  } node_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAD,
    ST_LEAF,
    ST_READ,
    ST_DECIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;    // latch the request
    logic load_step;  // store a load, close the run on the last one
    logic pad_step;   // pad one unloaded leaf
    logic upd_init;   // rewrite the winning leaf, start its path
    logic rd;         // read a sibling pair
    logic wr;         // decide the pair, write the parent
  } cmd_t;

  typedef struct packed {
    logic last_load;
    logic pad_done;
    logic at_root;
  } status_t;

endpackage

`default_nettype wire

[rtl/tts_ctrl.sv]
// ----------------------------------------------------------------------------
// tts_ctrl
// Sequencer for load, pad, build and path re-decision.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tournament_tree_min_select_assert.svh"

module tts_ctrl
  import tts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] operation,
  input  wire status_t    status,
  output cmd_t            cmd,
  output logic            busy,
  output logic            result_valid
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          case (operation) inside
            OP_LOAD:               state_next = ST_LOAD;
            OP_REPLACE, OP_RETIRE: state_next = ST_LEAF;
            default:               state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        state_next    = status.last_load ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        if (status.pad_done) begin
          state_next = ST_READ;
        end else begin
          cmd.pad_step = 1'b1;
        end
      end
      ST_LEAF: begin
        cmd.upd_init = 1'b1;
        state_next   = ST_READ;
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.wr     = 1'b1;
        state_next = status.at_root ? ST_EMIT : ST_READ;
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TTS_ASSERT_NXT(a_result_single, clk, rst, result_valid, !result_valid,
    "result strobe held longer than one cycle")
  `TTS_ASSERT_NXT(a_result_frees, clk, rst, result_valid, !busy,
    "block still busy after delivering a result")
  `TTS_ASSERT_NXT(a_op_goes_busy, clk, rst,
    start && !busy && (operation == OP_LOAD || operation == OP_REPLACE ||
    operation == OP_RETIRE), busy, "valid request did not start work")

endmodule

`default_nettype wire

[rtl/tts_datapath.sv]
// ----------------------------------------------------------------------------
// tts_datapath
// Node memory, run counters, config registers and the pair comparator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tournament_tree_min_select_assert.svh"

module tts_datapath
  import tts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire request_t                 request,
  input  wire cmd_t                     cmd,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output status_t                       status,
  output result_t                       result
);

  // heap-numbered nodes: root at 1, leaf i at LEAVES + i, entry 0 unused
  node_t mem [2*LEAVES];

  logic [WAYS_BITS-1:0] ways;
  logic [KEY_BITS-1:0]  pad_value;
  request_t             item;
  logic [CNT_BITS-1:0]  cnt, pidx;
  logic [NODE_BITS-1:0] q;        // left-or-self child of the pair in work
  node_t                rd_a, rd_b;
  logic [LEAF_BITS-1:0] root_leaf;
  logic [KEY_BITS-1:0]  root_key;
  logic                 err;

  logic [CNT_BITS-1:0]  lim, cnt_new;
  logic                 store_ok;
  node_t                win;
  logic [NODE_BITS-1:0] parent;
  logic                 mem_we;
  logic [NODE_BITS-1:0] mem_waddr;
  node_t                mem_wdata;

  always_comb begin
    lim      = (ways >= WAYS_BITS'(LEAVES)) ? CNT_BITS'(LEAVES) : CNT_BITS'(ways);
    store_ok = cnt < lim;
    cnt_new  = store_ok ? cnt + 1'b1 : cnt;
    // strict compare: on a tie the second of the pair wins
    win      = (rd_a.key < rd_b.key) ? rd_a : rd_b;
    parent   = q >> 1;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    if (cmd.load_step && store_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {1'b1, cnt[LEAF_BITS-1:0]};
      mem_wdata = '{key: item.value, leaf: cnt[LEAF_BITS-1:0]};
    end else if (cmd.pad_step) begin
      mem_we    = 1'b1;
      mem_waddr = {1'b1, pidx[LEAF_BITS-1:0]};
      mem_wdata = '{key: pad_value, leaf: pidx[LEAF_BITS-1:0]};
    end else if (cmd.upd_init) begin
      mem_we    = 1'b1;
      mem_waddr = {1'b1, root_leaf};
      mem_wdata = '{key: (item.operation == OP_REPLACE) ? item.value : pad_value,
                    leaf: root_leaf};
    end else if (cmd.wr) begin
      mem_we    = 1'b1;
      mem_waddr = parent;
      mem_wdata = win;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd) begin
      rd_a <= mem[q];
      rd_b <= mem[q ^ NODE_BITS'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ways      <= RESET_WAYS;
      pad_value <= RESET_PAD;
      cnt       <= '0;
      pidx      <= '0;
      q         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WAYS: ways      <= cfg_data[WAYS_BITS-1:0];
          CFG_PAD:  pad_value <= cfg_data[KEY_BITS-1:0];
          default:  ;
        endcase
      end
      if (cmd.load_step) begin
        if (item.last_load) begin
          cnt  <= '0;
          pidx <= cnt_new;
          q    <= BUILD_START;
        end else begin
          cnt <= cnt_new;
        end
      end
      if (cmd.pad_step) begin
        pidx <= pidx + 1'b1;
      end
      if (cmd.upd_init) begin
        q <= {1'b1, root_leaf};
      end
      if (cmd.wr) begin
        // build walks pairs downwards, an update climbs its path
        q <= (item.operation == OP_LOAD) ? q - NODE_BITS'(2) : parent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= request;
    end
    if (cmd.load_step && item.last_load) begin
      err <= (cnt_new != CNT_BITS'(ways));
    end
    if (cmd.upd_init) begin
      err <= 1'b0;
    end
    if (cmd.wr && parent == ROOT_NODE) begin
      root_leaf <= win.leaf;
      root_key  <= win.key;
    end
  end

  always_comb begin
    status.last_load    = item.last_load;
    status.pad_done     = (pidx == CNT_BITS'(LEAVES));
    status.at_root      = (parent == ROOT_NODE);
    result.winner_index = 4'(root_leaf);
    result.winner_value = root_key;
    result.load_error   = err;
  end

  `TTS_ASSERT_IMP(a_no_write_slot0, clk, rst, mem_we, mem_waddr != '0,
    "write to unused node slot")
  `TTS_ASSERT_IMP(a_pad_in_range, clk, rst, cmd.pad_step, pidx < CNT_BITS'(LEAVES),
    "padding beyond the last leaf")
  `TTS_ASSERT_NXT(a_root_is_min, clk, rst, cmd.wr && parent == ROOT_NODE,
    root_key <= $past(rd_a.key) && root_key <= $past(rd_b.key),
    "root key not the smaller of its children")

endmodule

`default_nettype wire

[rtl/tournament_tree_min_select.sv]
// ----------------------------------------------------------------------------
// tournament_tree_min_select
// Sequence: a non-final load stores its key; a final load also pads the
//   unloaded leaves and builds the 15 nodes pair by pair; replace/retire
//   rewrite the winning leaf and re-decide its path; both then strobe the
//   result, which is never stalled. One request at a time: idle again the
//   cycle after the strobe, or once a non-final load is stored.
// Reset (rst, synchronous): idle, ways 16, pad 0xFFFF, load count zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_tree_min_select
  import tts_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // request side: taken when start is high and busy low
  input  wire logic                     start,
  input  wire request_t                 request,
  output logic                          busy,
  // result side: one-cycle strobe, no back-pressure
  output logic                          result_valid,
  output result_t                       result,
  // configuration writes, only while idle
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  // Controller sequences each request; the datapath holds the whole tree
  // in one heap-numbered memory (leaves plus internal nodes), so both a
  // build and a path update reduce to "read a sibling pair, write the
  // parent" with one pointer.
  cmd_t    cmd;
  status_t status;

  tts_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (request.operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  tts_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cmd       (cmd),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tournament tree min select. A queue of pending
// requests and register writes feeds a falling-edge driver; a rising-edge
// monitor predicts the winner tree, keeps the expected results in order and
// compares every strobed result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import tts_pkg::*;

  localparam int RANDOM_ITEMS  = 1350;
  localparam int SETTLE_CYCLES = 12;      // quiet time before a register write
  localparam int DRAIN_CYCLES  = 64;      // longer than a full build
  localparam int CYCLE_LIMIT   = 600000;

  // operation code with no meaning; the block must ignore it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // one entry of the pending queue: a request or a register write
  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    request_t                 req;
    int                       gap;
  } pending_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     start        = 1'b0;
  request_t                 request      = '0;
  logic                     busy;
  logic                     result_valid;
  result_t                  result;
  logic                     cfg_write    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

  tournament_tree_min_select dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .request      (request),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Winner tree predictor: its own copy of the leaves, the node winners,
  // the load count and the two registers. Heap numbering, root at node 1,
  // leaf i at node LEAVES + i.
  // --------------------------------------------------------------------------
  bit [KEY_BITS-1:0]  leaf_key [LEAVES];
  bit [KEY_BITS-1:0]  win_key  [LEAVES];
  bit [LEAF_BITS-1:0] win_leaf [LEAVES];
  int                 load_count;
  int                 src_ways;
  bit [KEY_BITS-1:0]  pad_key;

  pending_t pending_q  [$];
  result_t  expected_q [$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       idle_cycles    = 0;
  bit       taken          = 1'b0;

  // generator bookkeeping
  int                 item_count = 0;
  int                 gen_ways   = 16;
  bit [KEY_BITS-1:0]  gen_pad    = 16'hFFFF;
  bit                 quiet      = 1'b0;

  function automatic bit [KEY_BITS-1:0] key_of(input int n);
    return (n >= LEAVES) ? leaf_key[n - LEAVES] : win_key[n];
  endfunction

  function automatic bit [LEAF_BITS-1:0] leaf_of(input int n);
    return (n >= LEAVES) ? LEAF_BITS'(n - LEAVES) : win_leaf[n];
  endfunction

  function automatic void clear_tree();
    for (int i = 0; i < LEAVES; i++) begin
      leaf_key[i] = '0;
      win_key[i]  = '0;
      win_leaf[i] = '0;
    end
    load_count = 0;
    src_ways   = int'(RESET_WAYS);
    pad_key    = RESET_PAD;
  endfunction

  function automatic void write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                         input logic [CFG_DATA_BITS-1:0] data);
    if (idx == CFG_WAYS)
      src_ways = int'(data[WAYS_BITS-1:0]);
    else if (idx == CFG_PAD)
      pad_key = data[KEY_BITS-1:0];
  endfunction

  // Applies one accepted request; says whether a result follows and what.
  function automatic void tree_step(input request_t req, output bit has_res,
                                    output result_t res);
    int lim;
    int n;
    int c;
    bit [LEAF_BITS-1:0] w;
    has_res = 1'b0;
    res     = '0;
    case (req.operation)
      OP_LOAD: begin
        lim = (src_ways < LEAVES) ? src_ways : LEAVES;
        if (load_count < lim) begin
          leaf_key[load_count] = req.value;
          load_count++;
        end
        if (req.last_load) begin
          for (n = load_count; n < LEAVES; n++)
            leaf_key[n] = pad_key;
          // bottom up; on a tie the right child takes the node
          for (n = LEAVES - 1; n >= 1; n--) begin
            c = (key_of(2 * n) < key_of(2 * n + 1)) ? 2 * n : 2 * n + 1;
            win_leaf[n] = leaf_of(c);
            win_key[n]  = key_of(c);
          end
          has_res          = 1'b1;
          res.winner_index = 4'(win_leaf[1]);
          res.winner_value = win_key[1];
          res.load_error   = (load_count != src_ways);
          load_count       = 0;
        end
      end
      OP_REPLACE, OP_RETIRE: begin
        w = win_leaf[1];
        leaf_key[w] = (req.operation == OP_REPLACE) ? req.value : pad_key;
        // climb the winner's path; on a tie the sibling takes the parent
        n = LEAVES + w;
        while (n > 1) begin
          c = (key_of(n) < key_of(n ^ 1)) ? n : n ^ 1;
          win_leaf[n >> 1] = leaf_of(c);
          win_key[n >> 1]  = key_of(c);
          n = n >> 1;
        end
        has_res          = 1'b1;
        res.winner_index = 4'(win_leaf[1]);
        res.winner_value = win_key[1];
        res.load_error   = 1'b0;
      end
      default: ;   // unused code: ignored
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("mismatch %0d at cycle %0d: %s", mismatch_count, cycle_count, what);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      return KEY_BITS'($urandom_range(0, 7));   // dense keys, many ties
    if (r < 45) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return '1;
        default: return gen_pad;
      endcase
    end
    return KEY_BITS'($urandom);
  endfunction

  task automatic add_req(input logic [1:0] op, input logic [KEY_BITS-1:0] val,
                         input logic last);
    pending_t p;
    p               = '{default: '0};
    p.req.operation = op;
    p.req.value     = val;
    p.req.last_load = last;
    p.gap           = pick_gap();
    pending_q.insert(pending_q.size(), p);
    if (op != OP_UNUSED)
      item_count++;
  endtask

  task automatic add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    pending_t p;
    p        = '{default: '0};
    p.is_cfg = 1'b1;
    p.idx    = idx;
    p.data   = data;
    p.gap    = pick_gap();
    pending_q.insert(pending_q.size(), p);
    if (idx == CFG_WAYS)
      gen_ways = int'(data[WAYS_BITS-1:0]);
    else
      gen_pad = data[KEY_BITS-1:0];
  endtask

  // A run of loads closed by a marked last one; mostly the right count.
  task automatic load_phase();
    int n;
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 7)
      n = (gen_ways == 0) ? $urandom_range(1, 3) : ((gen_ways > LEAVES) ? LEAVES : gen_ways);
    else if (kind < 9)
      n = $urandom_range(1, 20);
    else
      n = 1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0)
        add_req(OP_UNUSED, KEY_BITS'($urandom), 1'($urandom));
      add_req(OP_LOAD, pick_key(), i == n - 1);
    end
  endtask

  // A merge stretch: the winner is replaced or retired over and over.
  task automatic merge_phase();
    int m;
    int r;
    m = $urandom_range(0, 20);
    for (int i = 0; i < m; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)
        add_req(OP_REPLACE, pick_key(), 1'($urandom));
      else if (r < 95)
        add_req(OP_RETIRE, KEY_BITS'($urandom), 1'($urandom));
      else
        add_req(OP_UNUSED, KEY_BITS'($urandom), 1'($urandom));
    end
  endtask

  task automatic pick_config();
    int w;
    case ($urandom_range(0, 7))
      0:       w = 1;
      1:       w = 2;
      2:       w = 16;
      3:       w = 0;
      4:       w = $urandom_range(17, 31);
      default: w = $urandom_range(1, 16);
    endcase
    add_cfg(CFG_WAYS, CFG_DATA_BITS'(w));
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       add_cfg(CFG_PAD, '0);
        1:       add_cfg(CFG_PAD, '1);
        2:       add_cfg(CFG_PAD, CFG_DATA_BITS'($urandom_range(0, 7)));
        default: add_cfg(CFG_PAD, CFG_DATA_BITS'($urandom));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents the pending queue at the falling edge. A request stays
  // up until the monitor has seen it taken; a register write waits for the
  // block to have been quiet long enough.
  // --------------------------------------------------------------------------
  pending_t cur_item;
  bit       have_item = 1'b0;
  int       gap_left  = 0;

  always @(negedge clk) begin : driver
    bit start_n;
    bit write_n;
    if (rst) begin
      start     <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      start_n = 1'b0;
      write_n = 1'b0;
      if (start && !taken) begin
        start_n = 1'b1;                 // block still busy, hold the request
      end else begin
        if (!have_item && pending_q.size() != 0) begin
          cur_item  = pending_q.pop_front();
          have_item = 1'b1;
          gap_left  = cur_item.gap;
        end
        if (have_item) begin
          if (gap_left > 0) begin
            gap_left--;
          end else if (cur_item.is_cfg) begin
            if (idle_cycles >= SETTLE_CYCLES) begin
              write_n   = 1'b1;
              cfg_index <= cur_item.idx;
              cfg_data  <= cur_item.data;
              have_item = 1'b0;
            end
          end else begin
            start_n   = 1'b1;
            request   <= cur_item.req;
            have_item = 1'b0;
          end
        end
      end
      start     <= start_n;
      cfg_write <= write_n;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks strobed results against the oldest expectation, then
  // applies register writes and accepted requests to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit      has_res;
    result_t want;
    result_t pred;
    if (rst) begin
      clear_tree();
      taken       <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (result_valid) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result strobed with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (result.winner_index !== want.winner_index)
            report_mismatch($sformatf("winner_index got %0d want %0d",
                                      result.winner_index, want.winner_index));
          if (result.winner_value !== want.winner_value)
            report_mismatch($sformatf("winner_value got %h want %h",
                                      result.winner_value, want.winner_value));
          if (result.load_error !== want.load_error)
            report_mismatch($sformatf("load_error got %b want %b",
                                      result.load_error, want.load_error));
        end
      end
      if (cfg_write)
        write_register(cfg_index, cfg_data);
      if (start && !busy) begin
        tree_step(request, has_res, pred);
        if (has_res)
          expected_q.insert(expected_q.size(), pred);
      end
      taken <= start && !busy;
      // quiet time: nothing driven, nothing pending, nothing in flight
      if (start || busy || result_valid || cfg_write || expected_q.size() != 0)
        idle_cycles <= 0;
      else if (idle_cycles < 1000)
        idle_cycles <= idle_cycles + 1;
    end
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: fill the pending queue, reset, run, drain, verdict.
  // --------------------------------------------------------------------------
  initial begin : sequencer
    // directed: four ways, ties between equal keys and the pad value
    quiet = 1'b1;
    add_cfg(CFG_WAYS, 16'd4);
    add_cfg(CFG_PAD, 16'hFFFF);
    add_req(OP_LOAD, 16'hFFFF, 1'b0);
    add_req(OP_LOAD, 16'h0000, 1'b0);
    add_req(OP_LOAD, 16'h0007, 1'b0);
    add_req(OP_LOAD, 16'h0007, 1'b1);
    add_req(OP_REPLACE, 16'h0000, 1'b1);
    add_req(OP_REPLACE, 16'hFFFF, 1'b0);
    add_req(OP_RETIRE, 16'h1234, 1'b0);
    add_req(OP_UNUSED, 16'hFFFF, 1'b1);  // unused code, ignored
    add_req(OP_RETIRE, 16'h0000, 1'b1);
    add_req(OP_RETIRE, 16'hFFFF, 1'b0);
    // too many loads: the extra two are dropped, the last still builds
    for (int i = 0; i < 6; i++)
      add_req(OP_LOAD, 16'(5 - i), i == 5);
    // too few loads with a zero pad: count flagged, pad ties everywhere
    add_cfg(CFG_PAD, 16'h0000);
    add_req(OP_LOAD, 16'h0001, 1'b0);
    add_req(OP_LOAD, 16'h0000, 1'b1);
    add_req(OP_RETIRE, 16'h0000, 1'b0);
    // full width, a single load
    add_cfg(CFG_WAYS, 16'd16);
    add_cfg(CFG_PAD, 16'hFFFF);
    add_req(OP_LOAD, 16'h8000, 1'b1);
    add_req(OP_REPLACE, 16'h7FFF, 1'b0);

    // random: build, then merge for a while, with the odd register change
    item_count = 0;
    while (item_count < RANDOM_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        pick_config();
      load_phase();
      merge_phase();
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(pending_q.size() == 0 && !have_item && !start && expected_q.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));

    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
